### hw/rtl/dro_pkg.sv
// ----------------------------------------------------------------------------
// dro_pkg
// Shared constants and the register filter of the OPL pair-stream encoder.
// ----------------------------------------------------------------------------
`default_nettype none

package dro_pkg;

    localparam int unsigned CODE_W  = 7;
    localparam int unsigned MS_W    = 22;
    localparam int unsigned PROD_W  = 48;
    localparam int unsigned MAGIC_W = 29;
    localparam int unsigned QUO_W   = 61;
    localparam int unsigned QUO_LSB = 38;

    localparam logic [7:0] CMD_SHORT_DELAY = 8'hFF;
    localparam logic [7:0] CMD_LONG_DELAY  = 8'hFE;
    localparam logic [7:0] REG_OPL3_ENABLE = 8'h05;

    // ms saturates at 62 * 65536; the product bound is that figure times 1000
    localparam logic [MS_W-1:0]    DELAY_SAT = 22'd4063232;
    localparam logic [PROD_W-1:0]  PROD_SAT  = 48'd4063232000;
    // floor(x / 1000) == (x * DIV_MAGIC) >> 38 for every x below 4.9e9
    localparam logic [MAGIC_W-1:0] DIV_MAGIC = 29'd274877907;
    localparam logic [MS_W-1:0]    SHORT_MAX = 22'd256;

    typedef logic [CODE_W-1:0] code_t;
    typedef logic [MS_W-1:0]   ms_t;

    function automatic logic reg_allowed(input logic [7:0] r);
        logic ok;
        begin
            ok = (r == 8'h01) || (r == 8'h04) || (r == 8'h05) || (r == 8'h08) ||
                 (r == 8'hBD) ||
                 (r >= 8'h20 && r <= 8'h35) || (r >= 8'h40 && r <= 8'h55) ||
                 (r >= 8'h60 && r <= 8'h75) || (r >= 8'h80 && r <= 8'h95) ||
                 (r >= 8'hE0 && r <= 8'hF5) || (r >= 8'hA0 && r <= 8'hA8) ||
                 (r >= 8'hB0 && r <= 8'hB8) || (r >= 8'hC0 && r <= 8'hC8);
            return ok;
        end
    endfunction

endpackage

`default_nettype wire

### hw/rtl/dro_pair_stream_encoder_top.sv
// ----------------------------------------------------------------------------
// dro_pair_stream_encoder_top
// Turns OPL events into code/argument pairs: delay pairs first, then at most
// one register pair whose code is allocated on first use from a code map.
// ----------------------------------------------------------------------------
//  channel | direction | handshake           | payload
//  s_      | in        | s_valid / s_ready   | one event: delay and register write
//  m_      | out       | m_valid / m_ready   | one pair with status counters
//
//  One event at a time. Register-only event: code-map read on acceptance, then
//  read-modify-write. Delay event: multiply, divide by 1000 via reciprocal
//  multiply, accumulate, then the delay pairs one after another, then the
//  register pair. The code map is a 256-entry synchronous memory with
//  per-entry valid flags cleared by reset; no clearing pass.
//  A stalled m_ holds the sequencer; s_ready is high only when idle.
// ----------------------------------------------------------------------------
`default_nettype none

module dro_pair_stream_encoder_top #(
    parameter int unsigned MAX_CODES = 128
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_valid,
    output logic             s_ready,
    input  wire logic        s_has_delay,
    input  wire logic [23:0] s_delay_ticks,
    input  wire logic [23:0] s_us_per_tick,
    input  wire logic        s_has_reg,
    input  wire logic        s_chip,
    input  wire logic [7:0]  s_reg_addr,
    input  wire logic [7:0]  s_reg_value,
    output logic             m_valid,
    input  wire logic        m_ready,
    output logic [7:0]       m_code_byte,
    output logic [7:0]       m_arg_byte,
    output logic             m_last,
    output logic             m_overflow_error,
    output logic [1:0]       m_hw_type,
    output logic [31:0]      m_pair_count,
    output logic [31:0]      m_song_ms
);

    localparam int unsigned NC_W = $clog2(MAX_CODES + 1);

    localparam logic [2:0] ST_IDLE  = 3'd0;
    localparam logic [2:0] ST_MUL   = 3'd1;
    localparam logic [2:0] ST_DIV   = 3'd2;
    localparam logic [2:0] ST_SCALE = 3'd3;
    localparam logic [2:0] ST_EMIT  = 3'd4;
    localparam logic [2:0] ST_REG   = 3'd5;

    logic [2:0]  state_reg, state_next;
    logic [23:0] ticks_reg, usp_reg;
    logic        chip_reg, reg_emit_reg, hit_reg;
    logic [7:0]  addr_reg, value_reg;
    logic [dro_pkg::PROD_W-1:0] prod_reg;
    dro_pkg::ms_t quo_reg, ms_reg, ms_next;
    logic [31:0] total_ms_reg, total_ms_next;
    logic [31:0] pairs_reg, pairs_next;
    logic [1:0]  hw_reg, hw_next;
    logic [NC_W-1:0] next_code_reg, next_code_next;
    logic [255:0] map_valid_reg, map_valid_next;
    dro_pkg::code_t map_mem [256];
    dro_pkg::code_t map_rd_reg;

    logic        m_valid_reg, m_valid_next;
    logic [7:0]  out_code_next, out_arg_next;
    logic        out_last_next, out_err_next, out_load;

    logic        s_fire, out_free, s_reg_emit;
    logic        map_we;
    logic [dro_pkg::QUO_W-1:0] quo_full;
    dro_pkg::ms_t ms_calc, ms_after;
    logic [13:0] ms_hi;
    logic [7:0]  big;
    logic        is_long, emit_done;
    dro_pkg::code_t reg_code;

    assign s_ready    = (state_reg == ST_IDLE);
    assign s_fire     = s_valid && s_ready;
    assign out_free   = !m_valid_reg || m_ready;
    assign s_reg_emit = s_has_reg && dro_pkg::reg_allowed(s_reg_addr);
    assign m_valid    = m_valid_reg;

    assign quo_full = dro_pkg::QUO_W'(prod_reg[31:0]) * dro_pkg::QUO_W'(dro_pkg::DIV_MAGIC);
    assign ms_calc  = quo_reg;

    assign ms_hi     = ms_reg[dro_pkg::MS_W-1:8];
    assign is_long   = ms_reg > dro_pkg::SHORT_MAX;
    assign big       = (ms_hi > 14'd256) ? 8'hFF : 8'(ms_hi - 14'd1);
    assign ms_after  = ms_reg - {5'd0, {1'b0, big} + 9'd1, 8'd0};
    assign emit_done = !is_long || (ms_after == '0);
    assign reg_code  = hit_reg ? map_rd_reg : dro_pkg::CODE_W'(next_code_reg);

    always_comb begin
        state_next     = state_reg;
        ms_next        = ms_reg;
        total_ms_next  = total_ms_reg;
        pairs_next     = pairs_reg;
        hw_next        = hw_reg;
        next_code_next = next_code_reg;
        map_valid_next = map_valid_reg;
        map_we         = 1'b0;
        out_load       = 1'b0;
        out_code_next  = 8'd0;
        out_arg_next   = 8'd0;
        out_last_next  = 1'b0;
        out_err_next   = 1'b0;
        m_valid_next   = m_valid_reg && !m_ready;

        unique case (state_reg)
            ST_IDLE: begin
                if (s_fire) begin
                    priority if (s_has_delay) begin
                        state_next = ST_MUL;
                    end else if (s_reg_emit) begin
                        state_next = ST_REG;
                    end
                end
            end
            ST_MUL: begin
                state_next = ST_DIV;
            end
            ST_DIV: begin
                state_next = ST_SCALE;
            end
            ST_SCALE: begin
                ms_next       = ms_calc;
                total_ms_next = total_ms_reg + 32'(ms_calc);
                priority if (ms_calc != '0) begin
                    state_next = ST_EMIT;
                end else if (reg_emit_reg) begin
                    state_next = ST_REG;
                end else begin
                    state_next = ST_IDLE;
                end
            end
            ST_EMIT: begin
                if (out_free) begin
                    out_load      = 1'b1;
                    pairs_next    = pairs_reg + 32'd1;
                    out_last_next = emit_done && !reg_emit_reg;
                    if (is_long) begin
                        out_code_next = dro_pkg::CMD_LONG_DELAY;
                        out_arg_next  = big;
                        ms_next       = ms_after;
                    end else begin
                        out_code_next = dro_pkg::CMD_SHORT_DELAY;
                        out_arg_next  = 8'(ms_reg - 22'd1);
                        ms_next       = '0;
                    end
                    if (emit_done) begin
                        state_next = reg_emit_reg ? ST_REG : ST_IDLE;
                    end
                end
            end
            ST_REG: begin
                if (out_free) begin
                    out_load      = 1'b1;
                    out_last_next = 1'b1;
                    state_next    = ST_IDLE;
                    if (!hit_reg && (next_code_reg >= NC_W'(MAX_CODES))) begin
                        out_err_next = 1'b1;
                    end else begin
                        if (!hit_reg) begin
                            map_we                   = 1'b1;
                            map_valid_next[addr_reg] = 1'b1;
                            next_code_next           = next_code_reg + NC_W'(1);
                        end
                        out_code_next = {chip_reg, reg_code};
                        out_arg_next  = value_reg;
                        pairs_next    = pairs_reg + 32'd1;
                        if (chip_reg) begin
                            priority if (addr_reg == dro_pkg::REG_OPL3_ENABLE && value_reg[0]) begin
                                hw_next = 2'd2;
                            end else if (hw_reg == 2'd0) begin
                                hw_next = 2'd1;
                            end
                        end
                    end
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase

        if (out_load) begin
            m_valid_next = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            total_ms_reg  <= '0;
            pairs_reg     <= '0;
            hw_reg        <= '0;
            next_code_reg <= '0;
            map_valid_reg <= '0;
            m_valid_reg   <= 1'b0;
        end else begin
            state_reg     <= state_next;
            total_ms_reg  <= total_ms_next;
            pairs_reg     <= pairs_next;
            hw_reg        <= hw_next;
            next_code_reg <= next_code_next;
            map_valid_reg <= map_valid_next;
            m_valid_reg   <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_fire) begin
            ticks_reg    <= s_delay_ticks;
            usp_reg      <= s_us_per_tick;
            chip_reg     <= s_chip;
            addr_reg     <= s_reg_addr;
            value_reg    <= s_reg_value;
            reg_emit_reg <= s_reg_emit;
            hit_reg      <= map_valid_reg[s_reg_addr];
        end
        if (state_reg == ST_MUL) begin
            prod_reg <= dro_pkg::PROD_W'(ticks_reg) * dro_pkg::PROD_W'(usp_reg);
        end
        if (state_reg == ST_DIV) begin
            quo_reg <= (prod_reg >= dro_pkg::PROD_SAT) ? dro_pkg::DELAY_SAT :
                       quo_full[dro_pkg::QUO_LSB+dro_pkg::MS_W-1:dro_pkg::QUO_LSB];
        end
        ms_reg <= ms_next;
        if (out_load) begin
            m_code_byte      <= out_code_next;
            m_arg_byte       <= out_arg_next;
            m_last           <= out_last_next;
            m_overflow_error <= out_err_next;
            m_hw_type        <= hw_next;
            m_pair_count     <= pairs_next;
            m_song_ms        <= total_ms_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (map_we) begin
            map_mem[addr_reg] <= dro_pkg::CODE_W'(next_code_reg);
        end
        if (s_fire) begin
            map_rd_reg <= map_mem[s_reg_addr];
        end
    end

    a_emit_nonzero: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_EMIT) |-> (ms_reg != '0))
        else $error("delay sequencer running with nothing left");

    a_code_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        next_code_reg <= NC_W'(MAX_CODES))
        else $error("code allocator past its limit");

    a_err_pair: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid_reg && m_overflow_error) |->
            (m_code_byte == 8'd0 && m_arg_byte == 8'd0 && m_last))
        else $error("overflow transfer carries a pair");

    a_reg_ends: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_REG && out_free) |=> (state_reg == ST_IDLE && m_valid_reg && m_last))
        else $error("register pair did not close the event");

    a_hit_write: assert property (@(posedge aclk) disable iff (!aresetn)
        map_we |-> (!map_valid_reg[addr_reg] && state_reg == ST_REG))
        else $error("code map rewritten for an assigned register");

endmodule

`default_nettype wire

### test/dro_pair_stream_checker.sv
// ----------------------------------------------------------------------------
// dro_pair_stream_checker
// Watches both channels of the OPL pair-stream encoder, predicts the pairs
// each accepted event produces and compares every delivered pair against the
// oldest outstanding prediction, field by field.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module dro_pair_stream_checker #(
    parameter int unsigned MAX_CODES = 128
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_valid,
    input  wire logic        s_ready,
    input  wire logic        s_has_delay,
    input  wire logic [23:0] s_delay_ticks,
    input  wire logic [23:0] s_us_per_tick,
    input  wire logic        s_has_reg,
    input  wire logic        s_chip,
    input  wire logic [7:0]  s_reg_addr,
    input  wire logic [7:0]  s_reg_value,
    input  wire logic        m_valid,
    input  wire logic        m_ready,
    input  wire logic [7:0]  m_code_byte,
    input  wire logic [7:0]  m_arg_byte,
    input  wire logic        m_last,
    input  wire logic        m_overflow_error,
    input  wire logic [1:0]  m_hw_type,
    input  wire logic [31:0] m_pair_count,
    input  wire logic [31:0] m_song_ms,
    output int               fail_count,
    output int               pending_count,
    output int               pairs_checked,
    output int               overflows_checked
);

    typedef enum logic [1:0] {
        HW_OPL2      = 2'd0,
        HW_DUAL_OPL2 = 2'd1,
        HW_OPL3      = 2'd2
    } hw_kind_e;

    localparam logic [7:0]  CODE_FREE  = 8'hFF;
    localparam logic [7:0]  FILL_BYTE  = 8'h00;
    localparam logic [63:0] MS_CEILING = 64'd62 * 64'd65536;
    localparam logic [63:0] SHORT_SPAN = 64'd256;

    typedef struct packed {
        logic [7:0]  code;
        logic [7:0]  arg;
        logic        last;
        logic        err;
        logic [1:0]  hw;
        logic [31:0] pairs;
        logic [31:0] ms;
    } dro_pair_t;

    logic [7:0]  code_of_reg [256];
    logic [7:0]  codes_used;
    hw_kind_e    hw_now;
    logic [31:0] pairs_sent;
    logic [31:0] song_len;
    dro_pair_t   pending_pairs [$];
    dro_pair_t   want;
    int          burst_len;
    int          fails     = 0;
    int          checked   = 0;
    int          overflows = 0;

    function automatic logic opl_reg_ok(input logic [7:0] a);
        logic ok;
        case (a[7:4])
            4'h0: ok = (a == 8'h01) || (a == 8'h04) || (a == 8'h05) || (a == 8'h08);
            4'h2, 4'h4, 4'h6, 4'h8, 4'hE: ok = 1'b1;
            4'h3, 4'h5, 4'h7, 4'h9, 4'hF: ok = (a[3:0] <= 4'h5);
            4'hA, 4'hC: ok = (a[3:0] <= 4'h8);
            4'hB: ok = (a[3:0] <= 4'h8) || (a == 8'hBD);
            default: ok = 1'b0;
        endcase
        return ok;
    endfunction

    task automatic push_pair(input logic [7:0] code, input logic [7:0] arg, input logic err);
        dro_pair_t p;
        p.code  = code;
        p.arg   = arg;
        p.last  = 1'b0;
        p.err   = err;
        p.hw    = hw_now;
        p.pairs = pairs_sent;
        p.ms    = song_len;
        pending_pairs.insert(pending_pairs.size(), p);
        burst_len++;
    endtask

    task automatic encode_event(
        input logic        has_dly,
        input logic [23:0] ticks,
        input logic [23:0] usp,
        input logic        has_wr,
        input logic        chip,
        input logic [7:0]  addr,
        input logic [7:0]  val
    );
        logic [63:0] ms;
        logic [63:0] chunk;
        logic [7:0]  code;
        burst_len = 0;
        if (has_dly) begin
            ms = (64'(ticks) * 64'(usp)) / 64'd1000;
            if (ms > MS_CEILING) begin
                ms = MS_CEILING;
            end
            song_len = song_len + ms[31:0];
            while (ms != 64'd0) begin
                pairs_sent++;
                if (ms > SHORT_SPAN) begin
                    chunk = (ms >> 8) - 64'd1;
                    if (chunk > 64'd255) begin
                        chunk = 64'd255;
                    end
                    ms = ms - ((chunk + 64'd1) << 8);
                    push_pair(dro_pkg::CMD_LONG_DELAY, chunk[7:0], 1'b0);
                end else begin
                    push_pair(dro_pkg::CMD_SHORT_DELAY, 8'(ms - 64'd1), 1'b0);
                    ms = 64'd0;
                end
            end
        end
        if (has_wr && opl_reg_ok(addr)) begin
            if (code_of_reg[addr] == CODE_FREE && codes_used >= MAX_CODES) begin
                push_pair(FILL_BYTE, FILL_BYTE, 1'b1);
            end else begin
                if (code_of_reg[addr] == CODE_FREE) begin
                    code_of_reg[addr] = codes_used;
                    codes_used++;
                end
                code = code_of_reg[addr];
                if (chip) begin
                    code[7] = 1'b1;
                    if (addr == dro_pkg::REG_OPL3_ENABLE && val[0]) begin
                        hw_now = HW_OPL3;
                    end else if (hw_now == HW_OPL2) begin
                        hw_now = HW_DUAL_OPL2;
                    end
                end
                pairs_sent++;
                push_pair(code, val, 1'b0);
            end
        end
        if (burst_len > 0) begin
            pending_pairs[pending_pairs.size() - 1].last = 1'b1;
        end
    endtask

    task automatic check_field(input string name, input logic [31:0] exp_v,
                               input logic [31:0] act_v);
        if (act_v !== exp_v) begin
            $error("%s mismatch: expected 0x%0h, actual 0x%0h", name, exp_v, act_v);
            fails++;
        end
    endtask

    always @(posedge aclk) begin
        if (!aresetn) begin
            for (int r = 0; r < 256; r++) begin
                code_of_reg[r] = CODE_FREE;
            end
            codes_used = 8'd0;
            hw_now     = HW_OPL2;
            pairs_sent = 32'd0;
            song_len   = 32'd0;
            pending_pairs.delete();
        end else begin
            if (s_valid && s_ready) begin
                encode_event(s_has_delay, s_delay_ticks, s_us_per_tick, s_has_reg,
                             s_chip, s_reg_addr, s_reg_value);
            end
            if (m_valid && m_ready) begin
                if (pending_pairs.size() == 0) begin
                    $error("unexpected pair: code 0x%0h arg 0x%0h last %0b err %0b",
                           m_code_byte, m_arg_byte, m_last, m_overflow_error);
                    fails++;
                end else begin
                    want = pending_pairs.pop_front();
                    check_field("code_byte", 32'(want.code), 32'(m_code_byte));
                    check_field("arg_byte", 32'(want.arg), 32'(m_arg_byte));
                    check_field("last", 32'(want.last), 32'(m_last));
                    check_field("overflow_error", 32'(want.err), 32'(m_overflow_error));
                    check_field("hw_type", 32'(want.hw), 32'(m_hw_type));
                    check_field("pair_count", want.pairs, m_pair_count);
                    check_field("song_ms", want.ms, m_song_ms);
                    checked++;
                    if (want.err) begin
                        overflows++;
                    end
                end
            end
        end
        fail_count        <= fails;
        pending_count     <= pending_pairs.size();
        pairs_checked     <= checked;
        overflows_checked <= overflows;
    end

endmodule

### test/tb_dro_pair_stream_encoder_top.sv
// ----------------------------------------------------------------------------
// tb_dro_pair_stream_encoder_top
// Drives OPL events into the pair-stream encoder: a directed set covering
// delay conversion limits, the register filter, chip 1 handling and code
// reuse, then random events with idling and back-pressure on both channels.
// The checker beside the block predicts and compares; this module gives the
// verdict.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module tb_dro_pair_stream_encoder_top;

    localparam int unsigned MAX_CODES    = 128;
    localparam int          RESET_CYCLES = 5;
    localparam int          SINK_HOLD    = 300;
    localparam int          DRAIN_CYCLES = 20;

    logic        aclk          = 1'b0;
    logic        aresetn       = 1'b0;
    logic        s_valid       = 1'b0;
    logic        s_ready;
    logic        s_has_delay   = 1'b0;
    logic [23:0] s_delay_ticks = 24'd0;
    logic [23:0] s_us_per_tick = 24'd0;
    logic        s_has_reg     = 1'b0;
    logic        s_chip        = 1'b0;
    logic [7:0]  s_reg_addr    = 8'd0;
    logic [7:0]  s_reg_value   = 8'd0;
    logic        m_valid;
    logic        m_ready       = 1'b0;
    logic [7:0]  m_code_byte;
    logic [7:0]  m_arg_byte;
    logic        m_last;
    logic        m_overflow_error;
    logic [1:0]  m_hw_type;
    logic [31:0] m_pair_count;
    logic [31:0] m_song_ms;

    int fail_count;
    int pending_count;
    int pairs_checked;
    int overflows_checked;
    int events_offered = 0;
    bit no_idle        = 1'b0;
    bit hold_sink      = 1'b0;

    dro_pair_stream_encoder_top #(
        .MAX_CODES(MAX_CODES)
    ) i_dut (.*);

    dro_pair_stream_checker #(
        .MAX_CODES(MAX_CODES)
    ) i_checker (.*);

    always begin
        aclk = 1'b1;
        #5;
        aclk = 1'b0;
        #5;
    end

    function automatic int idle_gap();
        int r;
        r = $urandom_range(0, 99);
        if (no_idle || r < 55) begin
            return 0;
        end else if (r < 88) begin
            return $urandom_range(1, 3);
        end else if (r < 97) begin
            return $urandom_range(4, 12);
        end
        return $urandom_range(20, 60);
    endfunction

    function automatic logic [7:0] pick_opl_reg();
        int idx;
        logic [7:0] base;
        idx = $urandom_range(0, 141);
        if (idx < 5) begin
            case (idx)
                0: base = 8'h01;
                1: base = 8'h04;
                2: base = 8'h05;
                3: base = 8'h08;
                default: base = 8'hBD;
            endcase
            return base;
        end else if (idx < 115) begin
            case ((idx - 5) / 22)
                0: base = 8'h20;
                1: base = 8'h40;
                2: base = 8'h60;
                3: base = 8'h80;
                default: base = 8'hE0;
            endcase
            return base + 8'((idx - 5) % 22);
        end
        case ((idx - 115) / 9)
            0: base = 8'hA0;
            1: base = 8'hB0;
            default: base = 8'hC0;
        endcase
        return base + 8'((idx - 115) % 9);
    endfunction

    task automatic offer_event(
        input logic        has_dly,
        input logic [23:0] ticks,
        input logic [23:0] usp,
        input logic        has_wr,
        input logic        chip,
        input logic [7:0]  addr,
        input logic [7:0]  val
    );
        int gap;
        gap = idle_gap();
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid       <= 1'b1;
        s_has_delay   <= has_dly;
        s_delay_ticks <= ticks;
        s_us_per_tick <= usp;
        s_has_reg     <= has_wr;
        s_chip        <= chip;
        s_reg_addr    <= addr;
        s_reg_value   <= val;
        do @(posedge aclk); while (!s_ready);
        events_offered++;
    endtask

    // noise: random flags and any register address, often ignored by the block
    task automatic random_events(input int count);
        logic        hd;
        logic        hr;
        logic [23:0] ticks;
        logic [23:0] usp;
        for (int n = 0; n < count; n++) begin
            if ($urandom_range(0, 9) == 0) begin
                offer_event(1'($urandom_range(0, 1)), 24'($urandom), 24'($urandom),
                            1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
                            8'($urandom), 8'($urandom));
            end
            hd = ($urandom_range(0, 1) == 1);
            hr = ($urandom_range(0, 3) != 0);
            if (!hd && !hr) begin
                hr = 1'b1;
            end
            case ($urandom_range(0, 19))
                0: begin
                    ticks = 24'($urandom);
                    usp   = 24'($urandom);
                end
                1, 2, 3: begin
                    ticks = 24'($urandom_range(0, 65535));
                    usp   = 24'($urandom_range(0, 255));
                end
                default: begin
                    ticks = 24'($urandom_range(0, 600));
                    usp   = 24'($urandom_range(0, 3000));
                end
            endcase
            offer_event(hd, ticks, usp, hr, ($urandom_range(0, 2) == 0),
                        pick_opl_reg(), 8'($urandom));
        end
    endtask

    task automatic drain_pairs();
        s_valid <= 1'b0;
        @(posedge aclk);
        while (pending_count != 0) @(posedge aclk);
    endtask

    initial begin : sink_ready
        int run;
        int gap;
        forever begin
            if (hold_sink) begin
                m_ready <= 1'b0;
                repeat (SINK_HOLD) @(posedge aclk);
                hold_sink = 1'b0;
            end else if (no_idle) begin
                m_ready <= 1'b1;
                @(posedge aclk);
            end else begin
                run = $urandom_range(1, 6);
                m_ready <= 1'b1;
                repeat (run) @(posedge aclk);
                gap = idle_gap();
                if (gap > 0) begin
                    m_ready <= 1'b0;
                    repeat (gap) @(posedge aclk);
                end
            end
        end
    end

    initial begin : stimulus
        repeat (RESET_CYCLES) @(posedge aclk);
        aresetn <= 1'b1;

        // empty event, zero delays, delay conversion edges
        offer_event(1'b0, 24'd0, 24'd0, 1'b0, 1'b0, 8'h00, 8'h00);
        offer_event(1'b1, 24'hFFFFFF, 24'd0, 1'b0, 1'b0, 8'h00, 8'h00);
        offer_event(1'b1, 24'd0, 24'hFFFFFF, 1'b0, 1'b0, 8'h00, 8'h00);
        offer_event(1'b1, 24'd999, 24'd1, 1'b0, 1'b0, 8'h00, 8'h00);
        offer_event(1'b1, 24'd1000, 24'd1, 1'b0, 1'b0, 8'h00, 8'h00);
        offer_event(1'b1, 24'd256000, 24'd1, 1'b0, 1'b0, 8'h00, 8'h00);
        offer_event(1'b1, 24'd257000, 24'd1, 1'b0, 1'b0, 8'h00, 8'h00);
        offer_event(1'b1, 24'hFFFFFF, 24'hFFFFFF, 1'b1, 1'b0, 8'h01, 8'h00);
        offer_event(1'b0, 24'hFFFFFF, 24'hFFFFFF, 1'b1, 1'b0, 8'h01, 8'hFF);
        offer_event(1'b1, 24'd4063231, 24'd1000, 1'b1, 1'b0, 8'h04, 8'h5A);
        // register filter and chip 1 handling
        offer_event(1'b1, 24'd5000, 24'd1000, 1'b1, 1'b0, 8'h00, 8'h12);
        offer_event(1'b0, 24'd0, 24'd0, 1'b1, 1'b1, 8'hFF, 8'hAA);
        offer_event(1'b0, 24'd0, 24'd0, 1'b1, 1'b0, 8'hBD, 8'h20);
        offer_event(1'b0, 24'd0, 24'd0, 1'b1, 1'b1, 8'h20, 8'h55);
        offer_event(1'b0, 24'd0, 24'd0, 1'b1, 1'b0, 8'h35, 8'h81);
        offer_event(1'b0, 24'd0, 24'd0, 1'b1, 1'b0, 8'h36, 8'h81);
        offer_event(1'b0, 24'd0, 24'd0, 1'b1, 1'b1, 8'h05, 8'hFE);
        offer_event(1'b0, 24'd0, 24'd0, 1'b1, 1'b1, 8'h05, 8'h01);
        offer_event(1'b0, 24'd0, 24'd0, 1'b1, 1'b0, 8'hA8, 8'h0F);
        offer_event(1'b0, 24'd0, 24'd0, 1'b1, 1'b0, 8'hA9, 8'h0F);
        offer_event(1'b0, 24'd0, 24'd0, 1'b1, 1'b1, 8'hB8, 8'hF0);
        offer_event(1'b0, 24'd0, 24'd0, 1'b1, 1'b0, 8'hC8, 8'h3C);
        offer_event(1'b0, 24'd0, 24'd0, 1'b1, 1'b1, 8'hF5, 8'hC3);
        offer_event(1'b0, 24'd0, 24'd0, 1'b1, 1'b0, 8'hF6, 8'hC3);
        offer_event(1'b1, 24'd300, 24'd1000, 1'b1, 1'b0, 8'h08, 8'h40);

        random_events(160);

        // hold the sink off while events keep coming, then drain completely
        hold_sink = 1'b1;
        random_events(20);
        drain_pairs();

        no_idle = 1'b1;
        random_events(120);
        no_idle = 1'b0;
        random_events(120);

        drain_pairs();
        repeat (DRAIN_CYCLES) @(posedge aclk);

        $display("Summary: %0d events offered, %0d pairs checked, %0d of them code-map overflows",
                 events_offered, pairs_checked, overflows_checked);
        $display("Summary: saturated and boundary delays, filtered registers, long sink stall");
        if (fail_count == 0 && pending_count == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

    initial begin : watchdog
        #100_000_000;
        $display("Verification failed");
        $finish;
    end

endmodule
